>>> design/tcw_pkg.sv
// shared constants and control types of the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = ROW_W + COL_W;
  localparam int LIN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] BlankCode   = 8'h20;
  localparam logic [BYTE_W-1:0] NewlineCode = 8'h0A;
  localparam logic [BYTE_W-1:0] ResetAttr   = 8'h0F;

  localparam logic [1:0] ActWrite  = 2'd0;
  localparam logic [1:0] ActSetCur = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;
  localparam logic [1:0] ActRead   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic latch_item;
    logic wr_char;
    logic advance;
    logic newline;
    logic set_cur;
    logic home;
    logic scroll_cur;
    logic rd_cell;
    logic rd_capture;
    logic idx_clr;
    logic fill;
    logic init_fill;
    logic copy;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       code_zero;
    logic       code_nl;
    logic       tgt_ok;
    logic       wrap;
    logic       row_last;
    logic       fill_end;
    logic       move_end;
    logic       out_free;
  } sts_t;

endpackage

>>> design/tcw_ctrl.sv
// sequencing state machine of the text console writer
module tcw_ctrl import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StInit   = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StExec   = 3'd2;
  localparam logic [2:0] StRdWait = 3'd3;
  localparam logic [2:0] StScroll = 3'd4;
  localparam logic [2:0] StFill   = 3'd5;
  localparam logic [2:0] StResp   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StInit: begin
        cmd_o.fill      = 1'b1;
        cmd_o.init_fill = 1'b1;
        if (sts_i.fill_end) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = StExec;
        end
      end
      StExec: begin
        state_d = StResp;
        case (sts_i.action)
          ActWrite: begin
            if (!sts_i.code_zero) begin
              if (sts_i.code_nl) begin
                cmd_o.newline = 1'b1;
                if (sts_i.row_last) begin
                  cmd_o.scroll_cur = 1'b1;
                  cmd_o.idx_clr    = 1'b1;
                  state_d          = StScroll;
                end
              end else begin
                cmd_o.wr_char = 1'b1;
                cmd_o.advance = 1'b1;
                if (sts_i.wrap && sts_i.row_last) begin
                  cmd_o.scroll_cur = 1'b1;
                  cmd_o.idx_clr    = 1'b1;
                  state_d          = StScroll;
                end
              end
            end
          end
          ActSetCur: begin
            cmd_o.set_cur = sts_i.tgt_ok;
          end
          ActClear: begin
            cmd_o.home    = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d       = StFill;
          end
          ActRead: begin
            cmd_o.rd_cell = sts_i.tgt_ok;
            state_d       = StRdWait;
          end
          default: state_d = StResp;
        endcase
      end
      StRdWait: begin
        cmd_o.rd_capture = sts_i.tgt_ok;
        state_d          = StResp;
      end
      StScroll: begin
        if (sts_i.move_end) begin
          state_d = StFill;
        end else begin
          cmd_o.copy = 1'b1;
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_end) state_d = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tcw_datapath.sv
// cell buffer, cursor, sweep counter and result registers
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              cfg_valid_i,
  input  logic [BYTE_W-1:0] clear_attribute_i,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] char_code_i,
  input  logic [BYTE_W-1:0] attribute_i,
  input  logic [ROW_W-1:0]  target_row_i,
  input  logic [COL_W-1:0]  target_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  cursor_row_out_o,
  output logic [COL_W-1:0]  cursor_col_out_o,
  output logic [LIN_W-1:0]  cursor_linear_o,
  output logic [BYTE_W-1:0] read_char_o,
  output logic [BYTE_W-1:0] read_attribute_o,
  output logic              scrolled_o
);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic [BYTE_W-1:0] clr_attr_q;
  logic [1:0]        act_q;
  logic [BYTE_W-1:0] code_q, attr_q;
  logic [ROW_W-1:0]  trow_q;
  logic [COL_W-1:0]  tcol_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [AW-1:0]     idx_q;
  logic              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic [CELL_W-1:0] rdata_q;
  logic [BYTE_W-1:0] rd_char_q, rd_attr_q;
  logic              scr_q;
  logic              out_valid_q;
  logic [ROW_W-1:0]  o_row_q;
  logic [COL_W-1:0]  o_col_q;
  logic [LIN_W-1:0]  o_lin_q;
  logic [BYTE_W-1:0] o_char_q, o_attr_q;
  logic              o_scr_q;

  logic [POS_W-1:0]  cur_pos, tgt_pos;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;
  logic [BYTE_W-1:0] fill_attr;

  assign cur_pos = {{COL_W{1'b0}}, row_q} * POS_W'(COLUMNS) + {{ROW_W{1'b0}}, col_q};
  assign tgt_pos = {{COL_W{1'b0}}, trow_q} * POS_W'(COLUMNS) + {{ROW_W{1'b0}}, tcol_q};

  assign sts_o.action    = act_q;
  assign sts_o.code_zero = (code_q == '0);
  assign sts_o.code_nl   = (code_q == NewlineCode);
  assign sts_o.tgt_ok    = ({1'b0, trow_q} < (ROW_W + 1)'(ROWS)) &&
                           ({1'b0, tcol_q} < (COL_W + 1)'(COLUMNS));
  assign sts_o.wrap      = (col_q == COL_W'(COLUMNS - 1));
  assign sts_o.row_last  = (row_q == ROW_W'(ROWS - 1));
  assign sts_o.fill_end  = (idx_q == AW'(CELL_COUNT - 1));
  assign sts_o.move_end  = (idx_q == AW'(MOVE_COUNT));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // memory port muxing, a pending scroll copy owns the write port
  assign fill_attr = cmd_i.init_fill ? ResetAttr : clr_attr_q;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = {fill_attr, BlankCode};
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.fill) begin
      we = 1'b1;
    end else if (cmd_i.wr_char) begin
      we    = 1'b1;
      waddr = cur_pos[AW-1:0];
      wdata = {attr_q, code_q};
    end
  end

  assign re    = cmd_i.copy || cmd_i.rd_cell;
  assign raddr = cmd_i.copy ? (idx_q + AW'(COLUMNS)) : tgt_pos[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // cursor next value, scroll wins over the ordinary move
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.scroll_cur) begin
      row_d = ROW_W'(ROWS - 1);
      col_d = '0;
    end else if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.set_cur) begin
      row_d = trow_q;
      col_d = tcol_q;
    end else if (cmd_i.newline || (cmd_i.advance && sts_o.wrap)) begin
      row_d = row_q + 1'b1;
      col_d = '0;
    end else if (cmd_i.advance) begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_attr_q  <= ResetAttr;
      row_q       <= '0;
      col_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) clr_attr_q <= clear_attribute_i;
      row_q  <= row_d;
      col_q  <= col_d;
      pend_q <= cmd_i.copy;
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.fill || cmd_i.copy) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= idx_q;
    if (cmd_i.latch_item) begin
      act_q     <= action_i;
      code_q    <= char_code_i;
      attr_q    <= attribute_i;
      trow_q    <= target_row_i;
      tcol_q    <= target_col_i;
      rd_char_q <= '0;
      rd_attr_q <= '0;
      scr_q     <= 1'b0;
    end else begin
      if (cmd_i.scroll_cur) scr_q <= 1'b1;
      if (cmd_i.rd_capture) begin
        rd_char_q <= rdata_q[BYTE_W-1:0];
        rd_attr_q <= rdata_q[CELL_W-1:BYTE_W];
      end
    end
    if (cmd_i.out_load) begin
      o_row_q  <= row_q;
      o_col_q  <= col_q;
      o_lin_q  <= cur_pos[LIN_W-1:0];
      o_char_q <= rd_char_q;
      o_attr_q <= rd_attr_q;
      o_scr_q  <= scr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_row_out_o = o_row_q;
  assign cursor_col_out_o = o_col_q;
  assign cursor_linear_o  = o_lin_q;
  assign read_char_o      = o_char_q;
  assign read_attribute_o = o_attr_q;
  assign scrolled_o       = o_scr_q;

endmodule

>>> design/text_console_writer.sv
// text console writer: cell buffer with cursor, scroll, clear and cell read
// each item runs alone to its result: write, set cursor and zero or plain characters finish
//   straight from decode, a read cell waits on the buffer read, a clear blanks every cell, and a
//   write that scrolls copies the lines up and blanks the bottom line, one cell per cycle on the buffer port
// throughput: one item at a time, next transaction taken the cycle after its result is loaded
// reset: asynchronous active low; cursor to 0, clear attribute to 15, then a clearing
//   pass blanks all CELL_COUNT cells (2000 at 80x25) while input stays stalled
module text_console_writer import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BYTE_W-1:0] clear_attribute_i,
  // input item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [BYTE_W-1:0] char_code_i,
  input  logic [BYTE_W-1:0] attribute_i,
  input  logic [ROW_W-1:0]  target_row_i,
  input  logic [COL_W-1:0]  target_col_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  cursor_row_out_o,
  output logic [COL_W-1:0]  cursor_col_out_o,
  output logic [LIN_W-1:0]  cursor_linear_o,
  output logic [BYTE_W-1:0] read_char_o,
  output logic [BYTE_W-1:0] read_attribute_o,
  output logic              scrolled_o
);

  cmd_t cmd;
  sts_t sts;

  // the register is always writable; the user must write it only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // state machine: decodes the latched item and walks clear and scroll sweeps
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // buffer memory, cursor and the result register that decouples the output side
  tcw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .clear_attribute_i (clear_attribute_i),
    .action_i          (action_i),
    .char_code_i       (char_code_i),
    .attribute_i       (attribute_i),
    .target_row_i      (target_row_i),
    .target_col_i      (target_col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_row_out_o  (cursor_row_out_o),
    .cursor_col_out_o  (cursor_col_out_o),
    .cursor_linear_o   (cursor_linear_o),
    .read_char_o       (read_char_o),
    .read_attribute_o  (read_attribute_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

>>> verif/tb_text_console_writer.sv
// testbench of the text console writer: random and directed commands checked against a predictor
module tb_text_console_writer;
  import tcw_pkg::*;

  // one command as it goes into the block
  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] attr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_cmd_t;

  // one cursor report as it comes out of the block
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [LIN_W-1:0]  linear;
    logic [BYTE_W-1:0] rd_char;
    logic [BYTE_W-1:0] rd_attr;
    logic              scrolled;
  } cursor_report_t;

  localparam int MaxWait      = 18;
  localparam int RandPerPhase = 130;
  localparam int SettleCycles = 8;
  // no transaction for this long means the block hangs; the limit spans a scroll or clear
  // pass and the clearing pass after reset
  localparam int IdleLimit    = 10 * CELL_COUNT;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [BYTE_W-1:0] clear_attribute_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [BYTE_W-1:0] char_code_i;
  logic [BYTE_W-1:0] attribute_i;
  logic [ROW_W-1:0]  target_row_i;
  logic [COL_W-1:0]  target_col_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ROW_W-1:0]  cursor_row_out_o;
  logic [COL_W-1:0]  cursor_col_out_o;
  logic [LIN_W-1:0]  cursor_linear_o;
  logic [BYTE_W-1:0] read_char_o;
  logic [BYTE_W-1:0] read_attribute_o;
  logic              scrolled_o;

  text_console_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .clear_attribute_i(clear_attribute_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .attribute_i      (attribute_i),
    .target_row_i     (target_row_i),
    .target_col_i     (target_col_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_linear_o  (cursor_linear_o),
    .read_char_o      (read_char_o),
    .read_attribute_o (read_attribute_o),
    .scrolled_o       (scrolled_o)
  );

  // predicted console: character in the low byte, attribute in the high byte
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int                cur_row;
  int                cur_col;
  logic [BYTE_W-1:0] blank_attr;

  console_cmd_t   pending_cmds[$];
  cursor_report_t expected_reports[$];

  int errors;
  int idle_cycles;
  bit in_taken;
  bit out_taken;
  int in_wait;
  int out_wait;
  bit in_steady;
  bit out_steady;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen[i] = {blank_attr, BlankCode};
    end
  endfunction

  // move every line up by one and put a line of blanks at the bottom
  function automatic void scroll_screen();
    for (int i = 0; i < MOVE_COUNT; i++) begin
      screen[i] = screen[i + COLUMNS];
    end
    for (int i = MOVE_COUNT; i < CELL_COUNT; i++) begin
      screen[i] = {blank_attr, BlankCode};
    end
  endfunction

  // applies one command to the predicted console and returns the report it causes
  function automatic cursor_report_t apply_console_cmd(console_cmd_t c);
    cursor_report_t r;
    int             lin;
    bit             in_range;
    r = '0;
    in_range = (c.row < ROWS) && (c.col < COLUMNS);
    case (c.action)
      ActWrite: begin
        // a zero character leaves everything as it was
        if (c.code != 8'h00) begin
          if (c.code == NewlineCode) begin
            cur_row++;
            cur_col = 0;
          end else begin
            screen[cur_row * COLUMNS + cur_col] = {c.attr, c.code};
            cur_col++;
            if (cur_col >= COLUMNS) begin
              cur_row++;
              cur_col = 0;
            end
          end
          // ran off the bottom: scroll and park at the start of the last line
          if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROWS - 1;
            cur_col = 0;
            r.scrolled = 1'b1;
          end
        end
      end
      ActSetCur: begin
        // a position off the screen is ignored
        if (in_range) begin
          cur_row = c.row;
          cur_col = c.col;
        end
      end
      ActClear: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        // a read off the screen answers zeros
        if (in_range) begin
          r.rd_char = screen[c.row * COLUMNS + c.col][BYTE_W-1:0];
          r.rd_attr = screen[c.row * COLUMNS + c.col][CELL_W-1:BYTE_W];
        end
      end
    endcase
    lin = cur_row * COLUMNS + cur_col;
    r.row    = ROW_W'(cur_row);
    r.col    = COL_W'(cur_col);
    r.linear = LIN_W'(lin);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic console_cmd_t mk_cmd(logic [1:0] action, int code, int attr,
                                          int row, int col);
    console_cmd_t c;
    c.action = action;
    c.code   = BYTE_W'(code);
    c.attr   = BYTE_W'(attr);
    c.row    = ROW_W'(row);
    c.col    = COL_W'(col);
    return c;
  endfunction

  // mostly character writes, with cursor moves biased to the bottom line so that
  // scrolls happen often, and reads biased to the lines a scroll has just moved
  function automatic console_cmd_t make_random_cmd();
    console_cmd_t c;
    int           pick;
    int           sub;
    c = mk_cmd(ActWrite, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 31), $urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (pick < 55) begin
      if (sub < 8) begin
        c.code = NewlineCode;
      end else if (sub < 11) begin
        c.code = 8'h00;
      end
    end else if (pick < 70) begin
      c.action = ActSetCur;
      if (sub < 85) begin
        c.row = ROW_W'((sub < 35) ? ROWS - 1 : $urandom_range(0, ROWS - 1));
        c.col = COL_W'((sub < 20) ? COLUMNS - 1 - $urandom_range(0, 3)
                                  : $urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < 72) begin
      c.action = ActClear;
    end else begin
      c.action = ActRead;
      if (sub < 80) begin
        c.row = ROW_W'((sub < 45) ? $urandom_range(ROWS - 3, ROWS - 1)
                                  : $urandom_range(0, ROWS - 1));
        c.col = COL_W'((sub < 60) ? $urandom_range(0, 15) : $urandom_range(0, COLUMNS - 1));
      end
    end
    return c;
  endfunction

  // waits per transaction; a steady stretch has no waits at all
  function automatic int draw_wait(bit steady);
    return steady ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: presents queued commands at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_taken)) begin
        if (in_valid_i) begin
          // last command went in at the rising edge; draw the gap before the next
          if ($urandom_range(0, 39) == 0) begin
            in_steady = !in_steady;
          end
          in_wait = draw_wait(in_steady);
        end
        if (in_wait > 0) begin
          in_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          console_cmd_t c;
          c = pending_cmds.pop_front();
          action_i     <= c.action;
          char_code_i  <= c.code;
          attribute_i  <= c.attr;
          target_row_i <= c.row;
          target_col_i <= c.col;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side stall: a drawn number of cycles counted only while a result waits
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) begin
          out_steady = !out_steady;
        end
        out_wait = draw_wait(out_steady);
      end
      if (out_valid_o && out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every transaction is seen at the rising edge
  // ---------------------------------------------------------------------------

  task automatic check_report(cursor_report_t got);
    cursor_report_t exp;
    if (expected_reports.size() == 0) begin
      $error("cursor report with no command waiting: row %0d col %0d", got.row, got.col);
      errors++;
    end else begin
      exp = expected_reports.pop_front();
      if (got.row != exp.row) begin
        $error("cursor_row_out expected %0d actual %0d", exp.row, got.row);
        errors++;
      end
      if (got.col != exp.col) begin
        $error("cursor_col_out expected %0d actual %0d", exp.col, got.col);
        errors++;
      end
      if (got.linear != exp.linear) begin
        $error("cursor_linear expected %0d actual %0d", exp.linear, got.linear);
        errors++;
      end
      if (got.rd_char != exp.rd_char) begin
        $error("read_char expected 0x%02h actual 0x%02h", exp.rd_char, got.rd_char);
        errors++;
      end
      if (got.rd_attr != exp.rd_attr) begin
        $error("read_attribute expected 0x%02h actual 0x%02h", exp.rd_attr, got.rd_attr);
        errors++;
      end
      if (got.scrolled != exp.scrolled) begin
        $error("scrolled expected %0d actual %0d", exp.scrolled, got.scrolled);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      // results first, so a result never meets the command taken at the same edge
      if (out_valid_o && !out_stall_i) begin
        check_report({cursor_row_out_o, cursor_col_out_o, cursor_linear_o,
                      read_char_o, read_attribute_o, scrolled_o});
      end
      if (in_valid_i && !in_stall_o) begin
        expected_reports.push_back(apply_console_cmd({action_i, char_code_i, attribute_i,
                                                      target_row_i, target_col_i}));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        blank_attr = clear_attribute_i;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  // all queued commands in, every report back, then let the block settle
  task automatic wait_console_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_clear_attribute(logic [BYTE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    clear_attribute_i <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_directed();
    // reset fill, then plain characters at the byte extremes, a zero and a newline
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ActWrite, 8'h41, 8'hFF, 0, 0));
    pending_cmds.push_back(mk_cmd(ActWrite, 8'hFF, 8'h00, 31, 127));
    pending_cmds.push_back(mk_cmd(ActWrite, 8'h00, 8'h55, 0, 0));
    pending_cmds.push_back(mk_cmd(ActWrite, NewlineCode, 8'hAA, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 0, 1));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 0, 2));
    // wrap at the last cell scrolls the screen
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, ROWS - 1, COLUMNS - 1));
    pending_cmds.push_back(mk_cmd(ActWrite, 8'h7E, 8'h81, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 2, COLUMNS - 1));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 1, COLUMNS - 1));
    // cursor positions off the screen are ignored, reads there answer zeros
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, ROWS, 0));
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, 0, COLUMNS));
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, 31, 127));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 31, 127));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 1, COLUMNS));
    // newline on the last line scrolls too
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, ROWS - 1, 5));
    pending_cmds.push_back(mk_cmd(ActWrite, NewlineCode, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 3, COLUMNS - 1));
    // clear, then a wrap at the end of the top line
    pending_cmds.push_back(mk_cmd(ActClear, 0, 0, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 3, COLUMNS - 1));
    pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, 0, COLUMNS - 1));
    pending_cmds.push_back(mk_cmd(ActWrite, BlankCode, 8'h3C, 0, 0));
    pending_cmds.push_back(mk_cmd(ActRead, 0, 0, 0, COLUMNS - 1));
  endtask

  initial begin
    logic [BYTE_W-1:0] attr_settings [6];
    attr_settings = '{8'h00, 8'hFF, 8'h0E, 8'h00, 8'h00, ResetAttr};
    attr_settings[3] = BYTE_W'($urandom_range(0, 255));
    attr_settings[4] = BYTE_W'($urandom_range(0, 255));

    errors            = 0;
    idle_cycles       = 0;
    in_wait           = 0;
    out_wait          = $urandom_range(0, MaxWait);
    in_steady         = 1'b0;
    out_steady        = 1'b0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    clear_attribute_i = '0;
    in_valid_i        = 1'b0;
    action_i          = ActWrite;
    char_code_i       = '0;
    attribute_i       = '0;
    target_row_i      = '0;
    target_col_i      = '0;
    out_stall_i       = 1'b0;

    // predicted state after reset
    blank_attr = ResetAttr;
    cur_row    = 0;
    cur_col    = 0;
    blank_screen();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // the first commands run on the reset attribute, held back by the clearing pass
    queue_directed();

    foreach (attr_settings[p]) begin
      wait_console_idle();
      write_clear_attribute(attr_settings[p]);
      // a scroll right away shows the new attribute in the bottom line
      pending_cmds.push_back(mk_cmd(ActSetCur, 0, 0, ROWS - 1, 3));
      pending_cmds.push_back(mk_cmd(ActWrite, NewlineCode, 0, 0, 0));
      pending_cmds.push_back(mk_cmd(ActRead, 0, 0, ROWS - 1, 10));
      for (int i = 0; i < RandPerPhase; i++) begin
        pending_cmds.push_back(make_random_cmd());
      end
    end

    wait_console_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer.sv
verif/tb_text_console_writer.sv
